FILE: sv/rc5d_pkg.sv
// Shared constants, register codes and item types for the RC5 pulse decoder.
// No dependencies; every other file of the block imports this package.
package rc5d_pkg;

   localparam int FRAME_BITS   = 13;
   localparam int TICK_W       = 16;
   localparam int REMAIN_W     = 4;
   localparam int ADDR_W       = 5;
   localparam int CMD_W        = 7;
   localparam int CSR_INDEX_W  = 3;
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [TICK_W-1:0] HALF_MIN_RESET = 16'd600;
   localparam logic [TICK_W-1:0] HALF_MAX_RESET = 16'd1200;
   localparam logic [TICK_W-1:0] FULL_MIN_RESET = 16'd1500;
   localparam logic [TICK_W-1:0] FULL_MAX_RESET = 16'd2100;

   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_MIN = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_MAX = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FULL_MIN = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FULL_MAX = 3'd3;

   typedef enum logic [1:0] {
      CLS_HALF,
      CLS_FULL,
      CLS_BAD
   } pulse_class_type;

   typedef struct packed {
      pulse_class_type cls;
      logic            rising;
   } pulse_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

FILE: sv/rc5d_classify.sv
// Front part: holds the four window registers and classes each pulse item.
// Depends on rc5d_pkg.
module rc5d_classify
   import rc5d_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [TICK_W-1:0]      csr_write_data,
   input  logic [TICK_W-1:0]      pulse_ticks,
   input  logic                   edge_rising,
   output pulse_item_type         item
);

   logic [TICK_W-1:0] half_min_ff;
   logic [TICK_W-1:0] half_max_ff;
   logic [TICK_W-1:0] full_min_ff;
   logic [TICK_W-1:0] full_max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_min_ff <= HALF_MIN_RESET;
         half_max_ff <= HALF_MAX_RESET;
         full_min_ff <= FULL_MIN_RESET;
         full_max_ff <= FULL_MAX_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_HALF_MIN: half_min_ff <= csr_write_data;
            CSR_HALF_MAX: half_max_ff <= csr_write_data;
            CSR_FULL_MIN: full_min_ff <= csr_write_data;
            CSR_FULL_MAX: full_max_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      item.rising = edge_rising;
      priority if (pulse_ticks > half_min_ff && pulse_ticks < half_max_ff) begin
         item.cls = CLS_HALF;
      end else if (pulse_ticks > full_min_ff && pulse_ticks < full_max_ff) begin
         item.cls = CLS_FULL;
      end else begin
         item.cls = CLS_BAD;
      end
   end

endmodule

FILE: sv/rc5d_queue.sv
// Short queue of classed pulse items between the front and back parts.
// Depends on rc5d_pkg.
module rc5d_queue
   import rc5d_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pulse_item_type   push_item,
   input  logic             pop,
   output pulse_item_type   pop_item,
   output queue_status_type status
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   pulse_item_type   slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item     = slot_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

FILE: sv/rc5d_decode.sv
// Back part: bit tables, frame shift register and the registered result item.
// Depends on rc5d_pkg.
module rc5d_decode
   import rc5d_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  queue_status_type   queue_status,
   input  pulse_item_type     item,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               field_bit,
   output logic               toggle_bit,
   output logic [ADDR_W-1:0]  device_address,
   output logic [CMD_W-1:0]   command_code
);

   typedef enum logic [1:0] {
      OUT_ZERO,
      OUT_ONE,
      OUT_NONE,
      OUT_INV
   } outcome_type;

   localparam logic [REMAIN_W-1:0] REMAIN_RESET = REMAIN_W'(FRAME_BITS - 1);

   logic [FRAME_BITS-1:0] shift_ff, shift_in;
   logic [REMAIN_W-1:0]   remain_ff, remain_in;
   logic                  prev_ff, prev_in;
   logic                  await_ff, await_in;
   logic                  rsp_valid_ff;
   logic                  field_ff, toggle_ff;
   logic [ADDR_W-1:0]     addr_ff;
   logic [CMD_W-1:0]      cmd_ff;
   logic                  emit;
   logic [FRAME_BITS-1:0] frame;
   outcome_type           outcome;

   function automatic outcome_type lookup(logic prev, pulse_item_type it);
      outcome_type res;
      res = OUT_INV;
      if (it.rising) begin
         unique case ({prev, it.cls == CLS_FULL})
            2'b00: res = OUT_ZERO;
            2'b01: res = OUT_INV;
            2'b10: res = OUT_NONE;
            2'b11: res = OUT_ZERO;
            default: res = OUT_INV;
         endcase
      end else begin
         unique case ({prev, it.cls == CLS_FULL})
            2'b00: res = OUT_NONE;
            2'b01: res = OUT_ONE;
            2'b10: res = OUT_ONE;
            2'b11: res = OUT_INV;
            default: res = OUT_INV;
         endcase
      end
      return res;
   endfunction

   assign pop     = !queue_status.empty && (!rsp_valid_ff || !rsp_stall);
   assign outcome = lookup(prev_ff, item);
   assign frame   = shift_ff | FRAME_BITS'(outcome == OUT_ONE);

   always_comb begin
      shift_in  = shift_ff;
      remain_in = remain_ff;
      prev_in   = prev_ff;
      await_in  = await_ff;
      emit      = 1'b0;
      if (pop) begin
         priority if (!item.rising && await_ff) begin
            await_in = 1'b0;
         end else if (item.cls == CLS_BAD || outcome == OUT_INV) begin
            shift_in  = '0;
            remain_in = REMAIN_RESET;
            prev_in   = 1'b1;
            await_in  = 1'b1;
         end else if (outcome == OUT_NONE) begin
            shift_in = shift_ff;
         end else if (remain_ff != '0) begin
            prev_in   = (outcome == OUT_ONE);
            shift_in  = frame << 1;
            remain_in = remain_ff - REMAIN_W'(1);
         end else begin
            emit      = 1'b1;
            shift_in  = '0;
            remain_in = REMAIN_RESET;
            prev_in   = 1'b1;
            await_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff     <= '0;
         remain_ff    <= REMAIN_RESET;
         prev_ff      <= 1'b1;
         await_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         shift_ff  <= shift_in;
         remain_ff <= remain_in;
         prev_ff   <= prev_in;
         await_ff  <= await_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         field_ff  <= frame[FRAME_BITS-1];
         toggle_ff <= frame[FRAME_BITS-2];
         addr_ff   <= frame[FRAME_BITS-3 -: ADDR_W];
         cmd_ff    <= {~frame[FRAME_BITS-1], frame[CMD_W-2:0]};
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign field_bit      = field_ff;
   assign toggle_bit     = toggle_ff;
   assign device_address = addr_ff;
   assign command_code   = cmd_ff;

endmodule

FILE: sv/rc5_ir_pulse_decoder_core.sv
// Top level of the RC5 infrared pulse decoder: classifier, queue and decoder.
// Depends on rc5d_pkg, rc5d_classify, rc5d_queue and rc5d_decode.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_stall  pulse_ticks, edge_rising
//   rsp_      out        rsp_valid / rsp_stall  field, toggle, address, command
//   csr_      in         csr_write_enable       csr_index, csr_write_data
//
// One pulse item is accepted per cycle while req_stall is low; a pulse completing a frame
// is written into the queue, then decoded, and its result is registered on rsp_valid.
// Reset restores the window registers and clears the frame state.
// A stalled result holds the decoder, and req_stall rises once the queue is full.
module rc5_ir_pulse_decoder_core
   import rc5d_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [TICK_W-1:0]      req_pulse_ticks,
   input  logic                   req_edge_rising,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_field_bit,
   output logic                   rsp_toggle_bit,
   output logic [ADDR_W-1:0]      rsp_device_address,
   output logic [CMD_W-1:0]       rsp_command_code,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [TICK_W-1:0]      csr_write_data
);

   pulse_item_type   front_item;
   pulse_item_type   back_item;
   queue_status_type q_status;
   logic             push;
   logic             pop;

   assign req_stall = q_status.full;
   assign push      = req_valid && !req_stall;

   rc5d_classify u_classify (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .pulse_ticks      (req_pulse_ticks),
      .edge_rising      (req_edge_rising),
      .item             (front_item)
   );

   rc5d_queue #(
      .DEPTH (DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .pop       (pop),
      .pop_item  (back_item),
      .status    (q_status)
   );

   rc5d_decode u_decode (
      .clock          (clock),
      .reset          (reset),
      .queue_status   (q_status),
      .item           (back_item),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .field_bit      (rsp_field_bit),
      .toggle_bit     (rsp_toggle_bit),
      .device_address (rsp_device_address),
      .command_code   (rsp_command_code)
   );

   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("Queue reports full and empty together.");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("Decoder took an item from an empty queue.");

   a_result_from_pop: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(pop))
      else $error("Result item appeared without a decoded pulse.");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && !$past(pop)))
      else $error("Decoder advanced while its result item was stalled.");

endmodule

FILE: test/tb_rc5_ir_pulse_decoder_core.sv
// Self-checking testbench for rc5_ir_pulse_decoder_core, built on rc5d_pkg.
// Pulse items and window register writes go into the core, and a local decoder model predicts
// each frame, which is checked against what the core returns.
module tb_rc5_ir_pulse_decoder_core;
   import rc5d_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 16;
   localparam int REPORT_LIMIT = 10;
   localparam logic [REMAIN_W-1:0]    FRESH_REMAIN    = REMAIN_W'(FRAME_BITS - 1);
   localparam logic [CSR_INDEX_W-1:0] CSR_NO_REG_LOW  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_NO_REG_HIGH = 3'd7;

   typedef struct packed {
      logic              field_bit;
      logic              toggle_bit;
      logic [ADDR_W-1:0] device_address;
      logic [CMD_W-1:0]  command_code;
   } rc5_frame_type;

   typedef enum logic [1:0] {
      DEC_ZERO,
      DEC_ONE,
      DEC_NONE,
      DEC_INVALID
   } decode_outcome_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [TICK_W-1:0]      req_pulse_ticks;
   logic                   req_edge_rising;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic                   rsp_field_bit;
   logic                   rsp_toggle_bit;
   logic [ADDR_W-1:0]      rsp_device_address;
   logic [CMD_W-1:0]       rsp_command_code;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [TICK_W-1:0]      csr_write_data;

   logic [TICK_W-1:0]     win_half_min;
   logic [TICK_W-1:0]     win_half_max;
   logic [TICK_W-1:0]     win_full_min;
   logic [TICK_W-1:0]     win_full_max;
   logic [FRAME_BITS-1:0] frame_bits;
   logic [REMAIN_W-1:0]   bits_left;
   logic                  last_bit;
   logic                  wait_fall;

   rc5_frame_type expected_frames[$];
   int  items_sent      = 0;
   int  frames_checked  = 0;
   int  mismatch_count  = 0;
   int  window_settings = 0;
   int  cycle_count     = 0;
   bit  quiet           = 1'b0;

   rc5_ir_pulse_decoder_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_pulse_ticks    (req_pulse_ticks),
      .req_edge_rising    (req_edge_rising),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_field_bit      (rsp_field_bit),
      .rsp_toggle_bit     (rsp_toggle_bit),
      .rsp_device_address (rsp_device_address),
      .rsp_command_code   (rsp_command_code),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d frames outstanding.",
                  cycle_count, expected_frames.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic void clear_packet();
      frame_bits = '0;
      bits_left  = FRESH_REMAIN;
      last_bit   = 1'b1;
      wait_fall  = 1'b1;
   endfunction

   function automatic pulse_class_type classify_pulse(input logic [TICK_W-1:0] ticks);
      if (ticks > win_half_min && ticks < win_half_max)
         return CLS_HALF;
      if (ticks > win_full_min && ticks < win_full_max)
         return CLS_FULL;
      return CLS_BAD;
   endfunction

   function automatic void decode_pulse(input logic [TICK_W-1:0] ticks, input logic rising);
      pulse_class_type    cls;
      decode_outcome_type outcome;
      rc5_frame_type      frame;
      if (!rising && wait_fall) begin
         wait_fall = 1'b0;
         return;
      end
      cls = classify_pulse(ticks);
      if (cls == CLS_BAD) begin
         clear_packet();
         return;
      end
      case ({rising, last_bit})
         2'b10:   outcome = (cls == CLS_HALF) ? DEC_ZERO : DEC_INVALID;
         2'b11:   outcome = (cls == CLS_HALF) ? DEC_NONE : DEC_ZERO;
         2'b00:   outcome = (cls == CLS_HALF) ? DEC_NONE : DEC_ONE;
         default: outcome = (cls == CLS_HALF) ? DEC_ONE : DEC_INVALID;
      endcase
      if (outcome == DEC_NONE)
         return;
      if (outcome == DEC_INVALID) begin
         clear_packet();
         return;
      end
      last_bit   = (outcome == DEC_ONE);
      frame_bits = frame_bits | {{(FRAME_BITS-1){1'b0}}, last_bit};
      if (bits_left != '0) begin
         frame_bits = frame_bits << 1;
         bits_left  = bits_left - 1'b1;
         return;
      end
      frame.field_bit      = frame_bits[FRAME_BITS-1];
      frame.toggle_bit     = frame_bits[FRAME_BITS-2];
      frame.device_address = frame_bits[10:6];
      frame.command_code   = {~frame_bits[FRAME_BITS-1], frame_bits[5:0]};
      expected_frames.push_back(frame);
      clear_packet();
   endfunction

   function automatic int pick_idle_len();
      int roll;
      if (quiet)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 65)
         return 0;
      if (roll < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [TICK_W-1:0] pick_half_ticks();
      logic [TICK_W-1:0] ticks;
      if (int'(win_half_max) <= int'(win_half_min) + 1)
         return win_half_min;
      case ($urandom_range(0, 7))
         0:       ticks = win_half_min + 1'b1;
         1:       ticks = win_half_max - 1'b1;
         default: ticks = TICK_W'($urandom_range(int'(win_half_min) + 1,
                                                 int'(win_half_max) - 1));
      endcase
      return ticks;
   endfunction

   function automatic logic [TICK_W-1:0] pick_full_ticks();
      logic [TICK_W-1:0] ticks;
      if (int'(win_full_max) > int'(win_full_min) + 1) begin
         for (int tries = 0; tries < 20; tries++) begin
            ticks = TICK_W'($urandom_range(int'(win_full_min) + 1, int'(win_full_max) - 1));
            if (classify_pulse(ticks) == CLS_FULL)
               return ticks;
         end
      end
      return win_full_max;
   endfunction

   always @(posedge clock) begin
      rc5_frame_type wanted;
      rc5_frame_type seen;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = '{rsp_field_bit, rsp_toggle_bit, rsp_device_address, rsp_command_code};
         if (expected_frames.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("Unexpected frame at cycle %0d: field %0b toggle %0b address %0d command %0d",
                        cycle_count, seen.field_bit, seen.toggle_bit, seen.device_address,
                        seen.command_code);
         end else begin
            wanted = expected_frames.pop_front();
            frames_checked++;
            if (seen.field_bit !== wanted.field_bit || seen.toggle_bit !== wanted.toggle_bit ||
                seen.device_address !== wanted.device_address ||
                seen.command_code !== wanted.command_code) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("Frame mismatch at cycle %0d: expected field %0b toggle %0b %s",
                           cycle_count, wanted.field_bit, wanted.toggle_bit, "and");
                  $display("   address %0d command %0d, got field %0b toggle %0b",
                           wanted.device_address, wanted.command_code, seen.field_bit,
                           seen.toggle_bit);
                  $display("   address %0d command %0d",
                           seen.device_address, seen.command_code);
               end
            end
         end
      end
   end

   initial begin
      int hold;
      hold = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0)
            hold--;
         else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            hold = pick_idle_len();
         end else
            rsp_stall <= 1'b0;
      end
   end

   task automatic send_pulse(input logic [TICK_W-1:0] ticks, input logic rising);
      int gap;
      gap = pick_idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_pulse_ticks <= ticks;
      req_edge_rising <= rising;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      decode_pulse(ticks, rising);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_noise_pulse();
      logic [TICK_W-1:0] ticks;
      case ($urandom_range(0, 4))
         0:       ticks = pick_half_ticks();
         1:       ticks = pick_full_ticks();
         2, 3:    ticks = TICK_W'($urandom_range(0, 65535));
         default: begin
            case ($urandom_range(0, 3))
               0:       ticks = win_half_min;
               1:       ticks = win_half_max;
               2:       ticks = win_full_min;
               default: ticks = win_full_max;
            endcase
         end
      endcase
      send_pulse(ticks, 1'($urandom_range(0, 1)));
   endtask

   task automatic send_frame(input logic [FRAME_BITS-1:0] bits, input bit fillers,
                             input bit noisy);
      if (bits_left != FRESH_REMAIN || !last_bit || frame_bits != '0)
         send_pulse('0, 1'b1);
      if (wait_fall && $urandom_range(0, 1))
         send_pulse(TICK_W'($urandom_range(0, 65535)), 1'b0);
      for (int i = FRAME_BITS - 1; i >= 0; i--) begin
         if (noisy && $urandom_range(0, 15) == 0)
            send_noise_pulse();
         if (fillers && $urandom_range(0, 3) == 0)
            send_pulse(pick_half_ticks(), last_bit);
         if (bits[i]) begin
            if (wait_fall)
               send_pulse(TICK_W'($urandom_range(0, 65535)), 1'b0);
            send_pulse(last_bit ? pick_half_ticks() : pick_full_ticks(), 1'b0);
         end else
            send_pulse(last_bit ? pick_full_ticks() : pick_half_ticks(), 1'b1);
      end
   endtask

   task automatic run_traffic(input int count, input bit frames_ok);
      int stop_at;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         if (frames_ok && $urandom_range(0, 9) < 8)
            send_frame(FRAME_BITS'($urandom_range(0, 8191)), 1'($urandom_range(0, 1)),
                       $urandom_range(0, 7) == 0);
         else
            repeat ($urandom_range(1, 6)) send_noise_pulse();
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_frames.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_window(input logic [CSR_INDEX_W-1:0] index,
                               input logic [TICK_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
      case (index)
         CSR_HALF_MIN: win_half_min = value;
         CSR_HALF_MAX: win_half_max = value;
         CSR_FULL_MIN: win_full_min = value;
         CSR_FULL_MAX: win_full_max = value;
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic write_windows(input logic [TICK_W-1:0] half_min, input logic [TICK_W-1:0] half_max,
                                input logic [TICK_W-1:0] full_min, input logic [TICK_W-1:0] full_max);
      wait_idle();
      write_window(CSR_HALF_MIN, half_min);
      write_window(CSR_HALF_MAX, half_max);
      write_window(CSR_FULL_MIN, full_min);
      write_window(CSR_FULL_MAX, full_max);
      window_settings++;
   endtask

   task automatic test_directed_defaults();
      send_pulse(16'd0, 1'b0);
      send_pulse(16'd65535, 1'b1);
      send_pulse(16'd65535, 1'b0);
      send_pulse(16'd601, 1'b1);
      send_pulse(16'd1199, 1'b0);
      send_pulse(16'd1200, 1'b1);
      send_pulse(16'd2099, 1'b1);
      send_pulse(16'd1199, 1'b1);
      send_pulse(16'd1501, 1'b1);
      send_pulse(16'd600, 1'b0);
      send_pulse(16'd1501, 1'b0);
      send_pulse(16'd1, 1'b0);
      send_pulse(16'd1500, 1'b1);
      send_frame(13'h0FFF, 1'b0, 1'b0);
   endtask

   task automatic test_random_defaults();
      run_traffic(500, 1'b1);
   endtask

   task automatic test_tight_windows();
      write_windows(16'd99, 16'd101, 16'd199, 16'd201);
      quiet = 1'b1;
      run_traffic(250, 1'b1);
      quiet = 1'b0;
   endtask

   task automatic test_overlapping_windows();
      write_windows(16'd600, 16'd1600, 16'd1500, 16'd2100);
      run_traffic(200, 1'b1);
   endtask

   task automatic test_extreme_windows();
      write_windows(16'd0, 16'd0, 16'd0, 16'd0);
      run_traffic(60, 1'b0);
      write_windows(16'd0, 16'd65535, 16'd0, 16'd65535);
      run_traffic(60, 1'b0);
      write_windows(16'd65535, 16'd65535, 16'd65535, 16'd65535);
      wait_idle();
      write_window(CSR_NO_REG_LOW, 16'd1);
      write_window(CSR_NO_REG_HIGH, 16'hFFFE);
      run_traffic(60, 1'b0);
   endtask

   task automatic test_random_windows();
      int half_min;
      int half_max;
      int full_min;
      int full_max;
      repeat (4) begin
         half_min = $urandom_range(0, 1) ? $urandom_range(0, 2000) : $urandom_range(55000, 58000);
         half_max = half_min + $urandom_range(2, 2000);
         full_min = half_max - 1 + $urandom_range(0, 1000);
         full_max = full_min + $urandom_range(2, 3000);
         write_windows(TICK_W'(half_min), TICK_W'(half_max), TICK_W'(full_min),
                       TICK_W'(full_max));
         run_traffic(150, 1'b1);
      end
   endtask

   task automatic test_back_to_defaults();
      write_windows(HALF_MIN_RESET, HALF_MAX_RESET, FULL_MIN_RESET, FULL_MAX_RESET);
      run_traffic(200, 1'b1);
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_pulse_ticks  = '0;
      req_edge_rising  = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_HALF_MIN;
      csr_write_data   = '0;
      win_half_min     = HALF_MIN_RESET;
      win_half_max     = HALF_MAX_RESET;
      win_full_min     = FULL_MIN_RESET;
      win_full_max     = FULL_MAX_RESET;
      clear_packet();
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      test_directed_defaults();
      test_random_defaults();
      test_tight_windows();
      test_overlapping_windows();
      test_extreme_windows();
      test_random_windows();
      test_back_to_defaults();
      wait_idle();

      $display("Drove %0d pulse items through %0d window settings besides the reset values.",
               items_sent, window_settings);
      $display("Checked %0d decoded frames; %0d mismatches and %0d frames still outstanding.",
               frames_checked, mismatch_count, expected_frames.size());
      if (mismatch_count == 0 && expected_frames.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
